// ===== hw/rtl/kwmd_pkg.sv =====
// Shared widths, codes and types for the k-way merge with duplicate removal.
package kwmd_pkg;

    localparam int KEY_W    = 176;
    localparam int HIGH_W   = 64;
    localparam int MID_W    = 64;
    localparam int LOW_W    = 48;
    localparam int CNT_W    = 40;
    localparam int CFG_W    = 5;
    localparam int REFILL_W = 4;

    // Item opcodes.
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_END    = 1'b1;

    typedef logic [KEY_W-1:0] key_t;

    // Per-cycle command to the sorted cell row.
    typedef struct packed {
        logic ins;
        logic pop;
    } chain_ctl_t;

endpackage

// ===== hw/rtl/kway_merge_dedup.sv =====
// Top level of the k-way merge with duplicate removal over sorted runs.
//
// Usage: write runs_in_use on the cfg channel (cfg_valid/cfg_ready, ready is
// always high) while the block is idle. Then send one head request per run,
// runs 0 upward, on the input channel (in_valid/in_stall). Each later request
// either carries the next record of the run named by the last refill_run, or
// marks that run as ended (op high). The run_index field is not used; the
// block tracks which run each request belongs to.
// The last head request and every later request produce one result on the
// output channel (out_valid/out_stall): the least queued record, whether it
// differs from the previous record written, the run to refill next and the
// running unique count. When the queue is empty the result has finished set.
// Timing: a request is inserted into the sorted cell row in the cycle it is
// accepted. A request that pops then sets the pending flag, which holds
// in_stall high; once the output register is free or taken, the least record
// is popped into it. Head requests that give no result are taken every
// cycle. The insert and the pop each occupy the whole cell row.
// While the receiver stalls, the result holds and in_stall stays high once a
// pop is waiting. Reset empties the queue at once (per-cell valid bits), with
// no clearing pass, and sets runs_in_use to one.
module kway_merge_dedup
    import kwmd_pkg::*;
#(
    parameter int MAX_RUNS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                op,
    input  logic [3:0]          run_index,
    input  logic [HIGH_W-1:0]   record_high,
    input  logic [MID_W-1:0]    record_mid,
    input  logic [LOW_W-1:0]    record_low,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [HIGH_W-1:0]   out_high,
    output logic [MID_W-1:0]    out_mid,
    output logic [LOW_W-1:0]    out_low,
    output logic                is_new,
    output logic [REFILL_W-1:0] refill_run,
    output logic                finished,
    output logic [CNT_W-1:0]    unique_total
);

    localparam int FW = $clog2(MAX_RUNS + 1);
    localparam int TW = $clog2(MAX_RUNS);
    localparam int EW = (FW > CFG_W) ? FW : CFG_W;
    localparam logic [EW-1:0]    MAX_EXT = EW'(MAX_RUNS);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    logic [CFG_W-1:0]    runs_reg;
    logic [CFG_W-1:0]    runs_next;
    logic [FW-1:0]       fill_reg;
    logic [FW-1:0]       fill_next;
    logic [TW-1:0]       awaited_reg;
    logic [TW-1:0]       awaited_next;
    logic                pend_reg;
    logic                pend_next;
    logic                nothing_reg;
    logic                nothing_next;
    key_t                last_reg;
    key_t                last_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic [HIGH_W-1:0]   out_high_reg;
    logic [MID_W-1:0]    out_mid_reg;
    logic [LOW_W-1:0]    out_low_reg;
    logic                is_new_reg;
    logic [REFILL_W-1:0] refill_reg;
    logic                finished_reg;
    logic [CNT_W-1:0]    total_reg;

    logic [EW-1:0]       cfg_ext;
    logic [EW-1:0]       eff_ext;
    logic [FW-1:0]       eff;
    logic                in_fire;
    logic                pop_fire;
    logic                head_phase;
    logic                want_pop;
    logic [TW-1:0]       tag;
    logic [FW-1:0]       fill_inc;
    chain_ctl_t          ctl;
    key_t                new_key;
    logic                head_valid;
    key_t                head_key;
    logic [TW-1:0]       head_run;
    logic                full;
    logic                fresh;
    logic [TW+3:0]       run_wide;

    assign cfg_ready = 1'b1;
    assign runs_next = (cfg_valid && cfg_ready) ? cfg_data : runs_reg;

    // A register value of zero acts as one; values past the queue depth clamp.
    assign cfg_ext = EW'(runs_reg);
    always_comb
    begin
        if (cfg_ext == '0)
        begin
            eff_ext = EW'(1);
        end
        else if (cfg_ext > MAX_EXT)
        begin
            eff_ext = MAX_EXT;
        end
        else
        begin
            eff_ext = cfg_ext;
        end
    end
    assign eff = FW'(eff_ext);

    assign in_stall = pend_reg;
    assign in_fire  = in_valid && !in_stall;
    assign pop_fire = pend_reg && (!out_valid_reg || !out_stall);

    // During the head phase requests are filed under the fill count, later
    // under the run that the previous result asked for.
    assign head_phase = fill_reg < eff;
    assign fill_inc   = fill_reg + FW'(1);
    assign tag        = head_phase ? TW'(fill_reg) : awaited_reg;
    assign want_pop   = head_phase ? (fill_inc >= eff) : 1'b1;
    assign fill_next  = (in_fire && head_phase) ? fill_inc : fill_reg;
    assign pend_next  = in_fire ? want_pop : (pop_fire ? 1'b0 : pend_reg);

    assign new_key = {record_high, record_mid, record_low};
    assign ctl.ins = in_fire && (op == OP_RECORD) && !full;
    assign ctl.pop = pop_fire && head_valid;

    kwmd_chain #(
        .DEPTH (MAX_RUNS),
        .TW    (TW)
    ) u_chain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .new_key    (new_key),
        .new_run    (tag),
        .head_valid (head_valid),
        .head_key   (head_key),
        .head_run   (head_run),
        .full       (full)
    );

    // Duplicate check against the last record written.
    assign fresh    = nothing_reg || (head_key != last_reg);
    assign run_wide = {4'b0000, head_run};

    always_comb
    begin
        nothing_next = nothing_reg;
        last_next    = last_reg;
        count_next   = count_reg;
        awaited_next = awaited_reg;
        if (pop_fire && head_valid)
        begin
            awaited_next = head_run;
            if (fresh)
            begin
                nothing_next = 1'b0;
                last_next    = head_key;
                if (count_reg != CNT_MAX)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end
        end
    end

    assign out_valid_next = pop_fire || (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            runs_reg      <= CFG_W'(1);
            fill_reg      <= '0;
            awaited_reg   <= '0;
            pend_reg      <= 1'b0;
            nothing_reg   <= 1'b1;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            runs_reg      <= runs_next;
            fill_reg      <= fill_next;
            awaited_reg   <= awaited_next;
            pend_reg      <= pend_next;
            nothing_reg   <= nothing_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        last_reg <= last_next;
        if (pop_fire)
        begin
            total_reg <= count_next;
            if (head_valid)
            begin
                out_high_reg <= head_key[KEY_W-1 -: HIGH_W];
                out_mid_reg  <= head_key[LOW_W +: MID_W];
                out_low_reg  <= head_key[LOW_W-1:0];
                is_new_reg   <= fresh;
                refill_reg   <= run_wide[3:0];
                finished_reg <= 1'b0;
            end
            else
            begin
                out_high_reg <= '0;
                out_mid_reg  <= '0;
                out_low_reg  <= '0;
                is_new_reg   <= 1'b0;
                refill_reg   <= '0;
                finished_reg <= 1'b1;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_high     = out_high_reg;
    assign out_mid      = out_mid_reg;
    assign out_low      = out_low_reg;
    assign is_new       = is_new_reg;
    assign refill_run   = refill_reg;
    assign finished     = finished_reg;
    assign unique_total = total_reg;

endmodule

// ===== hw/rtl/kwmd_cell.sv =====
// One cell of the sorted queue: holds one record with its run tag.
module kwmd_cell
    import kwmd_pkg::*;
#(
    parameter int TW = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  chain_ctl_t    ctl,
    input  key_t          new_key,
    input  logic [TW-1:0] new_run,
    input  logic          left_lt,
    input  logic          left_valid,
    input  key_t          left_key,
    input  logic [TW-1:0] left_run,
    input  logic          right_valid,
    input  key_t          right_key,
    input  logic [TW-1:0] right_run,
    output logic          lt,
    output logic          valid,
    output key_t          key,
    output logic [TW-1:0] run
);

    logic          valid_reg;
    logic          valid_next;
    key_t          key_reg;
    key_t          key_next;
    logic [TW-1:0] run_reg;
    logic [TW-1:0] run_next;

    // The new record orders ahead of this cell's content (empty cells sort last).
    assign lt = !valid_reg || (new_key < key_reg) ||
                ((new_key == key_reg) && (new_run < run_reg));

    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        run_next   = run_reg;
        if (ctl.pop)
        begin
            valid_next = right_valid;
            key_next   = right_key;
            run_next   = right_run;
        end
        else if (ctl.ins)
        begin
            if (left_lt)
            begin
                valid_next = left_valid;
                key_next   = left_key;
                run_next   = left_run;
            end
            else if (lt)
            begin
                valid_next = 1'b1;
                key_next   = new_key;
                run_next   = new_run;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        run_reg <= run_next;
    end

    assign valid = valid_reg;
    assign key   = key_reg;
    assign run   = run_reg;

endmodule

// ===== hw/rtl/kwmd_chain.sv =====
// Row of sorted queue cells; cell 0 always holds the least record.
module kwmd_chain
    import kwmd_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int TW    = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  chain_ctl_t    ctl,
    input  key_t          new_key,
    input  logic [TW-1:0] new_run,
    output logic          head_valid,
    output key_t          head_key,
    output logic [TW-1:0] head_run,
    output logic          full
);

    logic [DEPTH-1:0] cell_valid;
    logic [DEPTH-1:0] cell_lt;
    key_t             cell_key [DEPTH];
    logic [TW-1:0]    cell_run [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic          l_lt;
        logic          l_valid;
        key_t          l_key;
        logic [TW-1:0] l_run;
        logic          r_valid;
        key_t          r_key;
        logic [TW-1:0] r_run;

        if (i == 0)
        begin : g_first
            assign l_lt    = 1'b0;
            assign l_valid = 1'b0;
            assign l_key   = '0;
            assign l_run   = '0;
        end
        else
        begin : g_inner_l
            assign l_lt    = cell_lt[i-1];
            assign l_valid = cell_valid[i-1];
            assign l_key   = cell_key[i-1];
            assign l_run   = cell_run[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign r_valid = 1'b0;
            assign r_key   = '0;
            assign r_run   = '0;
        end
        else
        begin : g_inner_r
            assign r_valid = cell_valid[i+1];
            assign r_key   = cell_key[i+1];
            assign r_run   = cell_run[i+1];
        end

        kwmd_cell #(
            .TW (TW)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .new_key     (new_key),
            .new_run     (new_run),
            .left_lt     (l_lt),
            .left_valid  (l_valid),
            .left_key    (l_key),
            .left_run    (l_run),
            .right_valid (r_valid),
            .right_key   (r_key),
            .right_run   (r_run),
            .lt          (cell_lt[i]),
            .valid       (cell_valid[i]),
            .key         (cell_key[i]),
            .run         (cell_run[i])
        );
    end

    // Occupied cells are always packed at the front of the row.
    assign full       = cell_valid[DEPTH-1];
    assign head_valid = cell_valid[0];
    assign head_key   = cell_key[0];
    assign head_run   = cell_run[0];

endmodule
